/* design/assert_macros.svh */
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/pbcq_pkg.sv */
// Package for the pooled block character queues: field widths and operation codes.
package pbcq_pkg;
	localparam int OP_W    = 2;
	localparam int QSEL_W  = 3;
	localparam int BYTE_W  = 8;
	localparam int CNTO_W  = 9;

	typedef enum logic [OP_W-1:0] {
		OP_PUT   = 2'd0,
		OP_GET   = 2'd1,
		OP_UNPUT = 2'd2,
		OP_FLUSH = 2'd3
	} op_t;
endpackage

/* design/pbcq_ifs.sv */
// Request and response channel interfaces of the pooled block character queues.
interface pbcq_req_if;
	logic                          valid;
	logic                          ready;
	logic [pbcq_pkg::OP_W-1:0]     op;
	logic [pbcq_pkg::QSEL_W-1:0]   queue_sel;
	logic [pbcq_pkg::BYTE_W-1:0]   data_byte;

	modport source(output valid, op, queue_sel, data_byte, input ready);
	modport sink(input valid, op, queue_sel, data_byte, output ready);
endinterface

interface pbcq_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [pbcq_pkg::BYTE_W-1:0]   data_out;
	logic                          status;
	logic [pbcq_pkg::CNTO_W-1:0]   room_left;
	logic [pbcq_pkg::CNTO_W-1:0]   byte_count;

	modport source(output valid, data_out, status, room_left, byte_count, input ready);
	modport sink(input valid, data_out, status, room_left, byte_count, output ready);
endinterface

/* design/pbcq_byte_mem.sv */
// Byte store of the block pool: one shared port, registered read data.
module pbcq_byte_mem #(
	parameter int DEPTH  = 2048,
	parameter int ADDR_W = 11
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [ADDR_W-1:0]           addr,
	input  logic [pbcq_pkg::BYTE_W-1:0] wdata,
	output logic [pbcq_pkg::BYTE_W-1:0] rdata
);
	logic [pbcq_pkg::BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

/* design/pbcq_link_mem.sv */
// Block link store: next and prev pointers per block, field write enables.
module pbcq_link_mem #(
	parameter int DEPTH = 64,
	parameter int IDX_W = 6,
	parameter int PTR_W = 7
) (
	input  logic             clk,
	input  logic [IDX_W-1:0] raddr,
	output logic [PTR_W-1:0] rd_next,
	output logic [PTR_W-1:0] rd_prev,
	input  logic [IDX_W-1:0] waddr,
	input  logic             we_next,
	input  logic [PTR_W-1:0] wdata_next,
	input  logic             we_prev,
	input  logic [PTR_W-1:0] wdata_prev
);
	typedef struct packed {
		logic [PTR_W-1:0] next;
		logic [PTR_W-1:0] prev;
	} link_t;

	link_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we_next) begin
			mem[waddr].next <= wdata_next;
		end
		if (we_prev) begin
			mem[waddr].prev <= wdata_prev;
		end
		rd_next <= mem[raddr].next;
		rd_prev <= mem[raddr].prev;
	end
endmodule

/* design/pooled_block_char_queues_top.sv */
// Top level of the pooled block character queues: sequencer, queue registers, memories.
// Put into a non-full tail block: execute, then finish; get and unput add a data step unless the queue is empty.
// Put that takes a fresh block adds a grow step, and a link step when the queue already has a tail.
// Flush: the flush state frees the held blocks in turn, one link-memory read per block.
// The result is loaded into the response registers in the finish state; one item at a time.
// Reset: all queues empty, free list 0..N-1 tracked by a fill count, no clearing pass.
`include "assert_macros.svh"

module pooled_block_char_queues_top #(
	parameter int BLOCK_BYTES      = 32,
	parameter int BLOCKS_PER_QUEUE = 8,
	parameter int POOL_BLOCKS      = 64,
	parameter int NUM_QUEUES       = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	pbcq_req_if.sink        req,
	pbcq_rsp_if.source      rsp
);
	localparam int PTR_W  = $clog2(POOL_BLOCKS + 1);
	localparam int IDX_W  = $clog2(POOL_BLOCKS);
	localparam int OFF_W  = $clog2(BLOCK_BYTES + 1);
	localparam int BLK_W  = $clog2(BLOCKS_PER_QUEUE + 1);
	localparam int CAP    = BLOCKS_PER_QUEUE * BLOCK_BYTES;
	localparam int CNT_W  = $clog2(CAP + 1);
	localparam int QI_W   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int ADDR_W = $clog2(POOL_BLOCKS * BLOCK_BYTES);
	localparam logic [PTR_W-1:0] NIL    = PTR_W'(POOL_BLOCKS);
	localparam logic [OFF_W-1:0] BB_OFF = OFF_W'(BLOCK_BYTES);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_EXEC  = 7'b0000010,
		S_GROW  = 7'b0000100,
		S_LINK  = 7'b0001000,
		S_DATA  = 7'b0010000,
		S_FLUSH = 7'b0100000,
		S_FIN   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	pbcq_pkg::op_t               op_q;
	logic [pbcq_pkg::QSEL_W-1:0] qsel_q;
	logic [pbcq_pkg::BYTE_W-1:0] byte_q;

	logic [pbcq_pkg::BYTE_W-1:0] data_q, data_d;
	logic                        status_q, status_d;
	logic                        have_q, have_d;
	logic                        drop_h_q, drop_h_d;
	logic                        drop_t_q, drop_t_d;
	logic                        single_q, single_d;
	logic [PTR_W-1:0]            blk_q, blk_d;
	logic [PTR_W-1:0]            tail_old_q, tail_old_d;

	logic [PTR_W-1:0] head_q   [NUM_QUEUES];
	logic [PTR_W-1:0] tail_q   [NUM_QUEUES];
	logic [BLK_W-1:0] blocks_q [NUM_QUEUES];
	logic [CNT_W-1:0] bytes_q  [NUM_QUEUES];
	logic [OFF_W-1:0] hs_q     [NUM_QUEUES];
	logic [OFF_W-1:0] te_q     [NUM_QUEUES];
	logic [PTR_W-1:0] free_head_q, fh_d;
	logic [PTR_W-1:0] fresh_q, fresh_d;

	logic [QI_W-1:0]  qi;
	logic             q_ok;
	logic [PTR_W-1:0] cur_h, cur_t;
	logic [BLK_W-1:0] cur_blocks;
	logic [CNT_W-1:0] cur_bytes;
	logic [OFF_W-1:0] cur_hs, cur_te;
	logic [OFF_W-1:0] cnt_h, cnt_t;
	logic [PTR_W-1:0] nx_head, nx_tail, nxt_free;
	logic [BLK_W-1:0] nx_blocks;
	logic [CNT_W-1:0] nx_bytes;
	logic [OFF_W-1:0] nx_hs, nx_te;
	logic             q_we;

	logic                        bm_we;
	logic [PTR_W-1:0]            bm_blk;
	logic [OFF_W-1:0]            bm_off;
	logic [ADDR_W-1:0]           bm_addr;
	logic [pbcq_pkg::BYTE_W-1:0] bm_rdata;

	logic [PTR_W-1:0] lm_raddr, lm_waddr, lm_wnext, lm_wprev;
	logic [PTR_W-1:0] lm_rd_next, lm_rd_prev;
	logic             lm_we_next, lm_we_prev;

	logic                        out_load, accept;
	logic [CNT_W-1:0]            fin_cnt;
	logic                        rsp_valid_q;
	logic [pbcq_pkg::BYTE_W-1:0] rsp_data_q;
	logic                        rsp_status_q;
	logic [pbcq_pkg::CNTO_W-1:0] rsp_room_q, rsp_count_q;

	assign qi         = QI_W'(qsel_q);
	assign q_ok       = int'(qsel_q) < NUM_QUEUES;
	assign cur_h      = head_q[qi];
	assign cur_t      = tail_q[qi];
	assign cur_blocks = blocks_q[qi];
	assign cur_bytes  = bytes_q[qi];
	assign cur_hs     = hs_q[qi];
	assign cur_te     = te_q[qi];
	assign cnt_h      = ((cur_h == cur_t) ? cur_te : BB_OFF) - cur_hs;
	assign cnt_t      = cur_te - ((cur_h == cur_t) ? cur_hs : '0);
	assign nxt_free   = (free_head_q < fresh_q) ? lm_rd_next : free_head_q + PTR_W'(1);

	assign out_load = (state_q == S_FIN) && (!rsp_valid_q || rsp.ready);
	assign req.ready = (state_q == S_IDLE) || out_load;
	assign accept   = req.valid && req.ready;
	assign fin_cnt  = q_ok ? cur_bytes : '0;

	assign bm_addr = ADDR_W'(bm_blk[IDX_W-1:0]) * ADDR_W'(BLOCK_BYTES) + ADDR_W'(bm_off);

	pbcq_byte_mem #(
		.DEPTH (POOL_BLOCKS * BLOCK_BYTES),
		.ADDR_W(ADDR_W)
	) u_byte_mem (
		.clk  (clk),
		.we   (bm_we),
		.addr (bm_addr),
		.wdata(byte_q),
		.rdata(bm_rdata)
	);

	pbcq_link_mem #(
		.DEPTH(POOL_BLOCKS),
		.IDX_W(IDX_W),
		.PTR_W(PTR_W)
	) u_link_mem (
		.clk       (clk),
		.raddr     (lm_raddr[IDX_W-1:0]),
		.rd_next   (lm_rd_next),
		.rd_prev   (lm_rd_prev),
		.waddr     (lm_waddr[IDX_W-1:0]),
		.we_next   (lm_we_next),
		.wdata_next(lm_wnext),
		.we_prev   (lm_we_prev),
		.wdata_prev(lm_wprev)
	);

	always_comb begin
		state_d    = state_q;
		data_d     = data_q;
		status_d   = status_q;
		have_d     = have_q;
		drop_h_d   = drop_h_q;
		drop_t_d   = drop_t_q;
		single_d   = single_q;
		blk_d      = blk_q;
		tail_old_d = tail_old_q;
		fh_d       = free_head_q;
		fresh_d    = fresh_q;
		nx_head    = cur_h;
		nx_tail    = cur_t;
		nx_blocks  = cur_blocks;
		nx_bytes   = cur_bytes;
		nx_hs      = cur_hs;
		nx_te      = cur_te;
		q_we       = 1'b0;
		bm_we      = 1'b0;
		bm_blk     = cur_h;
		bm_off     = cur_hs;
		lm_raddr   = cur_h;
		lm_waddr   = blk_q;
		lm_we_next = 1'b0;
		lm_wnext   = free_head_q;
		lm_we_prev = 1'b0;
		lm_wprev   = cur_t;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				data_d   = '0;
				status_d = 1'b0;
				have_d   = 1'b0;
				drop_h_d = 1'b0;
				drop_t_d = 1'b0;
				single_d = (cur_h == cur_t);
				state_d  = S_FIN;
				if (q_ok) begin
					unique case (op_q)
						pbcq_pkg::OP_PUT: begin
							if (cur_t != NIL && cur_te < BB_OFF) begin
								bm_we    = 1'b1;
								bm_blk   = cur_t;
								bm_off   = cur_te;
								nx_te    = cur_te + OFF_W'(1);
								nx_bytes = cur_bytes + CNT_W'(1);
								q_we     = 1'b1;
							end else if (cur_blocks >= BLK_W'(BLOCKS_PER_QUEUE)
									|| free_head_q == NIL) begin
								status_d = 1'b1;
							end else begin
								lm_raddr = free_head_q;
								state_d  = S_GROW;
							end
						end
						pbcq_pkg::OP_GET: begin
							if (cur_h != NIL) begin
								lm_raddr = cur_h;
								blk_d    = cur_h;
								drop_h_d = (cnt_h <= OFF_W'(1));
								state_d  = S_DATA;
								if (cnt_h != '0) begin
									bm_blk   = cur_h;
									bm_off   = cur_hs;
									nx_hs    = cur_hs + OFF_W'(1);
									nx_bytes = cur_bytes - CNT_W'(1);
									q_we     = 1'b1;
									have_d   = 1'b1;
								end
							end
						end
						pbcq_pkg::OP_UNPUT: begin
							if (cur_t != NIL) begin
								lm_raddr = cur_t;
								blk_d    = cur_t;
								drop_t_d = (cnt_t <= OFF_W'(1));
								state_d  = S_DATA;
								if (cnt_t != '0) begin
									bm_blk   = cur_t;
									bm_off   = cur_te - OFF_W'(1);
									nx_te    = cur_te - OFF_W'(1);
									nx_bytes = cur_bytes - CNT_W'(1);
									q_we     = 1'b1;
									have_d   = 1'b1;
								end
							end
						end
						pbcq_pkg::OP_FLUSH: begin
							if (cur_h != NIL) begin
								lm_raddr = cur_h;
								state_d  = S_FLUSH;
							end
						end
					endcase
				end
			end
			S_GROW: begin
				fh_d = nxt_free;
				if (free_head_q == fresh_q) begin
					fresh_d = fresh_q + PTR_W'(1);
				end
				lm_waddr   = free_head_q;
				lm_we_prev = 1'b1;
				lm_wprev   = cur_t;
				bm_we      = 1'b1;
				bm_blk     = free_head_q;
				bm_off     = '0;
				nx_tail    = free_head_q;
				nx_te      = OFF_W'(1);
				nx_blocks  = cur_blocks + BLK_W'(1);
				nx_bytes   = cur_bytes + CNT_W'(1);
				q_we       = 1'b1;
				blk_d      = free_head_q;
				tail_old_d = cur_t;
				if (cur_t == NIL) begin
					nx_head = free_head_q;
					nx_hs   = '0;
					state_d = S_FIN;
				end else begin
					state_d = S_LINK;
				end
			end
			S_LINK: begin
				lm_waddr   = tail_old_q;
				lm_we_next = 1'b1;
				lm_wnext   = blk_q;
				state_d    = S_FIN;
			end
			S_DATA: begin
				if (have_q) begin
					data_d = bm_rdata;
				end
				if (drop_h_q || drop_t_q) begin
					lm_waddr   = blk_q;
					lm_we_next = 1'b1;
					lm_wnext   = free_head_q;
					fh_d       = blk_q;
					nx_blocks  = cur_blocks - BLK_W'(1);
					q_we       = 1'b1;
					if (single_q) begin
						nx_head = NIL;
						nx_tail = NIL;
					end else if (drop_h_q) begin
						nx_head = lm_rd_next;
						nx_hs   = '0;
					end else begin
						nx_tail = lm_rd_prev;
						nx_te   = BB_OFF;
					end
				end
				state_d = S_FIN;
			end
			S_FLUSH: begin
				lm_waddr   = cur_h;
				lm_we_next = 1'b1;
				lm_wnext   = free_head_q;
				fh_d       = cur_h;
				q_we       = 1'b1;
				if (cur_h == cur_t) begin
					nx_head   = NIL;
					nx_tail   = NIL;
					nx_blocks = '0;
					nx_bytes  = '0;
					state_d   = S_FIN;
				end else begin
					nx_head  = lm_rd_next;
					lm_raddr = lm_rd_next;
				end
			end
			S_FIN: begin
				if (out_load) begin
					state_d = accept ? S_EXEC : S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_head_q <= '0;
			fresh_q     <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i]   <= NIL;
				tail_q[i]   <= NIL;
				blocks_q[i] <= '0;
				bytes_q[i]  <= '0;
				hs_q[i]     <= '0;
				te_q[i]     <= '0;
			end
		end else begin
			state_q     <= state_d;
			free_head_q <= fh_d;
			fresh_q     <= fresh_d;
			if (q_we) begin
				head_q[qi]   <= nx_head;
				tail_q[qi]   <= nx_tail;
				blocks_q[qi] <= nx_blocks;
				bytes_q[qi]  <= nx_bytes;
				hs_q[qi]     <= nx_hs;
				te_q[qi]     <= nx_te;
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= pbcq_pkg::op_t'(req.op);
			qsel_q <= req.queue_sel;
			byte_q <= req.data_byte;
		end
		data_q     <= data_d;
		status_q   <= status_d;
		have_q     <= have_d;
		drop_h_q   <= drop_h_d;
		drop_t_q   <= drop_t_d;
		single_q   <= single_d;
		blk_q      <= blk_d;
		tail_old_q <= tail_old_d;
		if (out_load) begin
			rsp_data_q   <= data_q;
			rsp_status_q <= status_q;
			rsp_count_q  <= pbcq_pkg::CNTO_W'(fin_cnt);
			rsp_room_q   <= pbcq_pkg::CNTO_W'(CNT_W'(CAP) - fin_cnt);
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.data_out   = rsp_data_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.room_left  = rsp_room_q;
	assign rsp.byte_count = rsp_count_q;

	`ASSERT_NXT(a_accept_exec, clk, arst_n, req.valid && req.ready, state_q == S_EXEC, "accepted transaction did not start")
	`ASSERT_IMP(a_grow_has_block, clk, arst_n, state_q == S_GROW, free_head_q != NIL, "block taken from empty free list")
	`ASSERT_IMP(a_rsp_from_fin, clk, arst_n, $rose(rsp.valid), $past(state_q == S_FIN), "response raised outside finish")
endmodule

/* verif/pbcq_tb_ifs_note.sv */
// Testbench item types of the pooled block character queues.
`timescale 1ns / 100ps
package pbcq_tb_pkg;
	typedef struct packed {
		pbcq_pkg::op_t                 op;
		logic [pbcq_pkg::QSEL_W-1:0]   queue_sel;
		logic [pbcq_pkg::BYTE_W-1:0]   data_byte;
	} req_item_t;

	typedef struct packed {
		logic [pbcq_pkg::BYTE_W-1:0]   data_out;
		logic                          status;
		logic [pbcq_pkg::CNTO_W-1:0]   room_left;
		logic [pbcq_pkg::CNTO_W-1:0]   byte_count;
	} rsp_item_t;
endpackage

/* verif/pooled_block_char_queues_top_tb.sv */
// Testbench of the pooled block character queues: linked-block queue predictor and scoreboard.
`timescale 1ns / 100ps
module pooled_block_char_queues_top_tb;
	localparam int BLK_SZ    = 32;
	localparam int BLK_LIMIT = 8;
	localparam int POOL_N    = 64;
	localparam int QUEUES_N  = 8;
	localparam int NIL       = POOL_N;
	localparam int CAP       = BLK_LIMIT * BLK_SZ;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RECV_HOLD_CYCLES = 300;

	logic clk;
	logic arst_n;

	pbcq_req_if req();
	pbcq_rsp_if rsp();

	pooled_block_char_queues_top #(
		.BLOCK_BYTES(BLK_SZ),
		.BLOCKS_PER_QUEUE(BLK_LIMIT),
		.POOL_BLOCKS(POOL_N),
		.NUM_QUEUES(QUEUES_N)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	// predictor state
	logic [7:0] pool_data [POOL_N*BLK_SZ];
	int blk_rd [POOL_N];
	int blk_wr [POOL_N];
	int blk_nxt [POOL_N];
	int blk_prv [POOL_N];
	int free_top;
	int q_first [QUEUES_N];
	int q_last [QUEUES_N];
	int q_nblk [QUEUES_N];
	int q_len [QUEUES_N];

	pbcq_tb_pkg::req_item_t pending_reqs[$];
	pbcq_tb_pkg::rsp_item_t expected_rsps[$];
	int errors;
	int send_idle_pct;
	int recv_idle_pct;
	int recv_hold;
	int hold_reqs;
	int hold_seen;
	int cycles;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	task automatic init_pool();
		for (int i = 0; i < POOL_N*BLK_SZ; i++) pool_data[i] = 8'd0;
		for (int i = 0; i < POOL_N; i++) begin
			blk_rd[i] = 0;
			blk_wr[i] = 0;
			blk_nxt[i] = i + 1;
			blk_prv[i] = NIL;
		end
		free_top = 0;
		for (int i = 0; i < QUEUES_N; i++) begin
			q_first[i] = NIL;
			q_last[i] = NIL;
			q_nblk[i] = 0;
			q_len[i] = 0;
		end
	endtask

	function automatic void free_block(int b);
		blk_prv[b] = NIL;
		blk_nxt[b] = free_top;
		free_top = b;
	endfunction

	function automatic int take_block(int q);
		int b;
		b = free_top;
		if (q_nblk[q] >= BLK_LIMIT || b >= NIL) return NIL;
		free_top = blk_nxt[b];
		blk_rd[b] = 0;
		blk_wr[b] = 0;
		blk_nxt[b] = NIL;
		blk_prv[b] = q_last[q];
		if (q_last[q] >= NIL) q_first[q] = b;
		else blk_nxt[q_last[q]] = b;
		q_last[q] = b;
		q_nblk[q]++;
		return b;
	endfunction

	function automatic void unlink_first(int q);
		int b;
		b = q_first[q];
		if (b >= NIL) return;
		if (b == q_last[q]) begin
			q_first[q] = NIL;
			q_last[q] = NIL;
		end else begin
			q_first[q] = blk_nxt[b];
			blk_prv[q_first[q]] = NIL;
		end
		q_len[q] -= blk_wr[b] - blk_rd[b];
		q_nblk[q]--;
		free_block(b);
	endfunction

	function automatic void unlink_last(int q);
		int b;
		b = q_last[q];
		if (b >= NIL) return;
		if (b == q_first[q]) begin
			q_first[q] = NIL;
			q_last[q] = NIL;
		end else begin
			q_last[q] = blk_prv[b];
			blk_nxt[q_last[q]] = NIL;
		end
		q_len[q] -= blk_wr[b] - blk_rd[b];
		q_nblk[q]--;
		free_block(b);
	endfunction

	function automatic pbcq_tb_pkg::rsp_item_t queue_step(pbcq_tb_pkg::req_item_t it);
		pbcq_tb_pkg::rsp_item_t r;
		int q, b, cnt;
		r = '0;
		q = it.queue_sel;
		cnt = 0;
		if (q < QUEUES_N) begin
			case (it.op)
				pbcq_pkg::OP_PUT: begin
					b = q_last[q];
					if (b >= NIL || blk_wr[b] >= BLK_SZ) b = take_block(q);
					if (b >= NIL) r.status = 1'b1;
					else begin
						pool_data[b*BLK_SZ + blk_wr[b]] = it.data_byte;
						blk_wr[b]++;
						q_len[q]++;
					end
				end
				pbcq_pkg::OP_GET: begin
					b = q_first[q];
					if (b < NIL) begin
						if (blk_rd[b] < blk_wr[b]) begin
							r.data_out = pool_data[b*BLK_SZ + blk_rd[b]];
							blk_rd[b]++;
							q_len[q]--;
						end
						if (blk_rd[b] >= blk_wr[b]) unlink_first(q);
					end
				end
				pbcq_pkg::OP_UNPUT: begin
					b = q_last[q];
					if (b < NIL) begin
						if (blk_wr[b] > blk_rd[b]) begin
							blk_wr[b]--;
							r.data_out = pool_data[b*BLK_SZ + blk_wr[b]];
							q_len[q]--;
						end
						if (blk_wr[b] <= blk_rd[b]) unlink_last(q);
					end
				end
				default: begin
					while (q_first[q] < NIL) unlink_first(q);
				end
			endcase
			cnt = q_len[q];
		end
		r.room_left = 9'((CAP - cnt) & 'h1FF);
		r.byte_count = 9'(cnt & 'h1FF);
		return r;
	endfunction

	task automatic add_item(pbcq_pkg::op_t op, int q, int d);
		pbcq_tb_pkg::req_item_t it;
		it.op = op;
		it.queue_sel = q[pbcq_pkg::QSEL_W-1:0];
		it.data_byte = d[pbcq_pkg::BYTE_W-1:0];
		pending_reqs.push_back(it);
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	bit req_taken;
	always @(posedge clk) begin
		req_taken <= arst_n && req.valid && req.ready;
		if (arst_n && req.valid && req.ready) begin
			expected_rsps.push_back(queue_step(pending_reqs.pop_front()));
		end
	end

	// driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.op <= '0;
			req.queue_sel <= '0;
			req.data_byte <= '0;
		end else if (!req.valid || req_taken) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				req.valid <= 1'b1;
				req.op <= pending_reqs[0].op;
				req.queue_sel <= pending_reqs[0].queue_sel;
				req.data_byte <= pending_reqs[0].data_byte;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		pbcq_tb_pkg::rsp_item_t got;
		pbcq_tb_pkg::rsp_item_t exp_r;
		if (!arst_n) begin
			errors = 0;
		end else if (rsp.valid && rsp.ready) begin
			got.data_out = rsp.data_out;
			got.status = rsp.status;
			got.room_left = rsp.room_left;
			got.byte_count = rsp.byte_count;
			if (expected_rsps.size() == 0) begin
				$display("%0t: unexpected transaction, actual %h", $realtime, got);
				errors++;
			end else begin
				exp_r = expected_rsps.pop_front();
				if (got !== exp_r) begin
					$display("%0t: mismatch data %h/%h status %b/%b room %0d/%0d count %0d/%0d",
						$realtime, exp_r.data_out, got.data_out, exp_r.status, got.status,
						exp_r.room_left, got.room_left, exp_r.byte_count, got.byte_count);
					errors++;
				end
			end
		end
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			recv_hold <= 0;
			hold_seen <= 0;
		end else if (hold_reqs != hold_seen) begin
			hold_seen <= hold_reqs;
			recv_hold <= RECV_HOLD_CYCLES;
			rsp.ready <= 1'b0;
		end else if (recv_hold > 0) begin
			recv_hold <= recv_hold - 1;
			rsp.ready <= 1'b0;
		end else rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycles <= 0;
		end else begin
			cycles <= cycles + 1;
			if (cycles > CYCLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic random_phase(int n);
		int q, r;
		for (int i = 0; i < n; i++) begin
			q = ($urandom_range(15) == 0) ? 8 + 0 : $urandom_range(3);
			q = (q == 8) ? $urandom_range(7) : q;
			r = $urandom_range(99);
			if (r < 50) add_item(pbcq_pkg::OP_PUT, q, $urandom_range(255));
			else if (r < 75) add_item(pbcq_pkg::OP_GET, q, $urandom_range(255));
			else if (r < 95) add_item(pbcq_pkg::OP_UNPUT, q, $urandom_range(255));
			else add_item(pbcq_pkg::OP_FLUSH, q, $urandom_range(255));
			if (pending_reqs.size() > 40)
				while (pending_reqs.size() > 10) @(posedge clk);
		end
		wait_drained();
	endtask

	initial begin
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_reqs = 0;
		init_pool();
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed
		add_item(pbcq_pkg::OP_GET, 0, 8'hFF);
		add_item(pbcq_pkg::OP_UNPUT, 0, 0);
		add_item(pbcq_pkg::OP_FLUSH, 0, 0);
		add_item(pbcq_pkg::OP_PUT, 0, 8'h00);
		add_item(pbcq_pkg::OP_PUT, 0, 8'hFF);
		add_item(pbcq_pkg::OP_PUT, 7, 8'hA5);
		add_item(pbcq_pkg::OP_PUT, 7, 8'h5A);
		add_item(pbcq_pkg::OP_UNPUT, 7, 0);
		add_item(pbcq_pkg::OP_GET, 0, 0);
		add_item(pbcq_pkg::OP_GET, 0, 0);
		add_item(pbcq_pkg::OP_GET, 0, 0);
		add_item(pbcq_pkg::OP_FLUSH, 7, 0);
		for (int i = 0; i < 260; i++) add_item(pbcq_pkg::OP_PUT, 3, i);
		hold_reqs++;
		wait_drained();
		for (int i = 0; i < 40; i++) add_item(pbcq_pkg::OP_GET, 3, 0);
		for (int i = 0; i < 40; i++) add_item(pbcq_pkg::OP_UNPUT, 3, 0);
		add_item(pbcq_pkg::OP_FLUSH, 3, 0);
		wait_drained();

		send_idle_pct = 23;
		recv_idle_pct = 82;
		random_phase(520);
		send_idle_pct = 82;
		recv_idle_pct = 23;
		random_phase(520);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(510);
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_rsps.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

/* pooled_block_char_queues_top.f */
+incdir+design
design/pbcq_pkg.sv
design/pbcq_ifs.sv
design/pbcq_byte_mem.sv
design/pbcq_link_mem.sv
design/pooled_block_char_queues_top.sv
verif/pbcq_tb_ifs_note.sv
verif/pooled_block_char_queues_top_tb.sv
